// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the timer table RTL.
// Each macro wraps one clocked, reset-qualified concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define DTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dtt_pkg.sv =====
// Package for the deadline timer table: sizes, action and status codes, types.
// Used by dtt_cmp_unit and deadline_timer_table_unit; depends on nothing.
`timescale 1ns / 1ps

package dtt_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int SLOT_BITS   = 4;
    localparam int TAG_BITS    = 16;
    localparam int TIME_BITS   = 32;
    localparam int ORDER_BITS  = 32;
    localparam int REFS_BITS   = 8;
    localparam int ACTION_BITS = 3;
    localparam int STATUS_BITS = 3;

    // Reference count limits.
    localparam logic signed [REFS_BITS-1:0] REFS_MAX  = 8'sd127;
    localparam logic signed [REFS_BITS-1:0] REFS_ONE  = 8'sd1;
    localparam logic signed [REFS_BITS-1:0] REFS_ZERO = 8'sd0;

    // Action codes.
    localparam logic [ACTION_BITS-1:0] ACT_SET     = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_QUERY   = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_FIRE    = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_FIND    = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_ADDREF  = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_RELEASE = 3'd5;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] STS_OK           = 3'd0;
    localparam logic [STATUS_BITS-1:0] STS_FULL         = 3'd1;
    localparam logic [STATUS_BITS-1:0] STS_EMPTY        = 3'd2;
    localparam logic [STATUS_BITS-1:0] STS_NOT_DUE      = 3'd3;
    localparam logic [STATUS_BITS-1:0] STS_NOT_FOUND    = 3'd4;
    localparam logic [STATUS_BITS-1:0] STS_SLOT_INVALID = 3'd5;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } dtt_state_t;

    // Outcome of comparing a candidate entry against the reference operands.
    typedef struct packed {
        logic lt;      // candidate time below reference time
        logic eq;      // candidate time equal to reference time
        logic older;   // candidate inserted before the reference entry
    } dtt_cmp_t;

endpackage

// ===== hdl/dtt_cmp_unit.sv =====
// Shared compare unit of the timer table scan: time order and insertion age.
// Depends on dtt_pkg for widths and the result struct.
`timescale 1ns / 1ps

module dtt_cmp_unit (
    input  logic [dtt_pkg::TIME_BITS-1:0]  cand_time,
    input  logic [dtt_pkg::TIME_BITS-1:0]  ref_time,
    input  logic [dtt_pkg::ORDER_BITS-1:0] cand_age,
    input  logic [dtt_pkg::ORDER_BITS-1:0] ref_age,
    output dtt_pkg::dtt_cmp_t              result
);

    // One magnitude and one equality compare on the deadlines, one magnitude compare on the ages.
    always_comb
    begin
        result.lt    = cand_time < ref_time;
        result.eq    = cand_time == ref_time;
        result.older = cand_age > ref_age;
    end

endmodule

// ===== hdl/deadline_timer_table_unit.sv =====
// Top level of the deadline timer table: sequencer, entry store and result register.
// Depends on dtt_pkg, dtt_cmp_unit and assert_macros.svh.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    action, now, time_value, owner_tag, slot
//   out      from block out_valid / out_stall  status, fired_tag, fired, wait_seconds,
//                                              found_slot
//
// Set, query, fire and find walk all sixteen entries through the shared compare unit,
// one entry a cycle. Addref, release and the unused actions skip the walk.
// One beat is in work at a time; in_stall is high from acceptance until the result
// has moved into the output register, which a stalled out channel may hold back.
// Reset clears the valid bits, the insertion counter and all control state at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module deadline_timer_table_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [dtt_pkg::ACTION_BITS-1:0]  action,
    input  logic [dtt_pkg::TIME_BITS-1:0]    now,
    input  logic [dtt_pkg::TIME_BITS-1:0]    time_value,
    input  logic [dtt_pkg::TAG_BITS-1:0]     owner_tag,
    input  logic [dtt_pkg::SLOT_BITS-1:0]    slot,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [dtt_pkg::STATUS_BITS-1:0]  status,
    output logic [dtt_pkg::TAG_BITS-1:0]     fired_tag,
    output logic                             fired,
    output logic [dtt_pkg::TIME_BITS-1:0]    wait_seconds,
    output logic [dtt_pkg::SLOT_BITS-1:0]    found_slot
);

    localparam logic [dtt_pkg::IDX_BITS-1:0] IDX_LAST = dtt_pkg::IDX_BITS'(dtt_pkg::TABLE_DEPTH - 1);

    // Sequencer and latched beat.
    dtt_pkg::dtt_state_t               state_reg, state_next;
    logic [dtt_pkg::ACTION_BITS-1:0]   action_reg, action_next;
    logic [dtt_pkg::TIME_BITS-1:0]     now_reg, now_next;
    logic [dtt_pkg::TIME_BITS-1:0]     tval_reg, tval_next;
    logic [dtt_pkg::TAG_BITS-1:0]      tag_reg, tag_next;
    logic [dtt_pkg::IDX_BITS-1:0]      idx_reg, idx_next;

    // Best candidate found so far in the walk.
    logic                              found_reg, found_next;
    logic [dtt_pkg::IDX_BITS-1:0]      best_idx_reg, best_idx_next;
    logic [dtt_pkg::TIME_BITS-1:0]     best_time_reg, best_time_next;
    logic [dtt_pkg::ORDER_BITS-1:0]    best_age_reg, best_age_next;
    logic [dtt_pkg::TAG_BITS-1:0]      best_tag_reg, best_tag_next;

    // Table state.
    logic [dtt_pkg::TABLE_DEPTH-1:0]   valid_reg, valid_next;
    logic [dtt_pkg::ORDER_BITS-1:0]    insert_counter_reg, insert_counter_next;
    logic [dtt_pkg::TIME_BITS-1:0]     deadline_mem [dtt_pkg::TABLE_DEPTH];
    logic [dtt_pkg::TAG_BITS-1:0]      tag_mem      [dtt_pkg::TABLE_DEPTH];
    logic signed [dtt_pkg::REFS_BITS-1:0] refs_mem  [dtt_pkg::TABLE_DEPTH];
    logic [dtt_pkg::ORDER_BITS-1:0]    order_mem    [dtt_pkg::TABLE_DEPTH];

    // Registered read port of the entry store, addressed by idx_next.
    logic [dtt_pkg::TIME_BITS-1:0]     rd_time_reg;
    logic [dtt_pkg::TAG_BITS-1:0]      rd_tag_reg;
    logic signed [dtt_pkg::REFS_BITS-1:0] rd_refs_reg;
    logic [dtt_pkg::ORDER_BITS-1:0]    rd_order_reg;

    // Write port controls.
    logic                              set_we;
    logic                              refs_we;
    logic [dtt_pkg::IDX_BITS-1:0]      wr_addr;
    logic [dtt_pkg::TIME_BITS-1:0]     wr_time;
    logic signed [dtt_pkg::REFS_BITS-1:0] wr_refs;

    // Output register.
    logic                              out_valid_reg, out_valid_next;
    logic [dtt_pkg::STATUS_BITS-1:0]   status_reg, status_next;
    logic [dtt_pkg::TAG_BITS-1:0]      fired_tag_reg, fired_tag_next;
    logic                              fired_reg, fired_next;
    logic [dtt_pkg::TIME_BITS-1:0]     wait_reg, wait_next;
    logic [dtt_pkg::SLOT_BITS-1:0]     found_slot_reg, found_slot_next;

    // Compare unit operands and helpers.
    logic [dtt_pkg::TIME_BITS-1:0]     cmp_ref_time;
    logic [dtt_pkg::ORDER_BITS-1:0]    cand_age;
    dtt_pkg::dtt_cmp_t                 cmp;
    logic                              cand_valid;
    logic                              take;
    logic                              out_free;
    logic [dtt_pkg::TIME_BITS:0]       sum_wide;

    // Shared compare unit, used once per scanned entry.
    assign cand_age     = insert_counter_reg - rd_order_reg;
    assign cmp_ref_time = (action_reg == dtt_pkg::ACT_FIND) ? tval_reg : best_time_reg;

    dtt_cmp_unit u_cmp (
        .cand_time (rd_time_reg),
        .ref_time  (cmp_ref_time),
        .cand_age  (cand_age),
        .ref_age   (best_age_reg),
        .result    (cmp)
    );

    assign cand_valid = valid_reg[idx_reg];
    assign out_free   = !out_valid_reg || !out_stall;
    assign sum_wide   = {1'b0, now_reg} + {1'b0, tval_reg};

    // Whether the entry under the scan index replaces the best candidate.
    always_comb
    begin
        case (action_reg)
            dtt_pkg::ACT_SET:
                take = !found_reg && !cand_valid;
            dtt_pkg::ACT_QUERY, dtt_pkg::ACT_FIRE:
                take = cand_valid && (!found_reg || cmp.lt || (cmp.eq && cmp.older));
            dtt_pkg::ACT_FIND:
                take = cand_valid && cmp.eq && (rd_tag_reg == tag_reg) &&
                       (!found_reg || cmp.older);
            default:
                take = 1'b0;
        endcase
    end

    // Sequencer: next state, scan bookkeeping, table updates and the result.
    always_comb
    begin
        state_next          = state_reg;
        action_next         = action_reg;
        now_next            = now_reg;
        tval_next           = tval_reg;
        tag_next            = tag_reg;
        idx_next            = idx_reg;
        found_next          = found_reg;
        best_idx_next       = best_idx_reg;
        best_time_next      = best_time_reg;
        best_age_next       = best_age_reg;
        best_tag_next       = best_tag_reg;
        valid_next          = valid_reg;
        insert_counter_next = insert_counter_reg;
        set_we              = 1'b0;
        refs_we             = 1'b0;
        wr_addr             = idx_reg;
        wr_time             = sum_wide[dtt_pkg::TIME_BITS-1:0];
        wr_refs             = rd_refs_reg;
        out_valid_next      = out_valid_reg && out_stall;
        status_next         = status_reg;
        fired_tag_next      = fired_tag_reg;
        fired_next          = fired_reg;
        wait_next           = wait_reg;
        found_slot_next     = found_slot_reg;

        case (state_reg)
            dtt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = action;
                    now_next    = now;
                    tval_next   = time_value;
                    tag_next    = owner_tag;
                    found_next  = 1'b0;
                    if (action inside {dtt_pkg::ACT_SET, dtt_pkg::ACT_QUERY,
                                       dtt_pkg::ACT_FIRE, dtt_pkg::ACT_FIND})
                    begin
                        idx_next   = '0;
                        state_next = dtt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        idx_next   = dtt_pkg::IDX_BITS'(slot);
                        state_next = dtt_pkg::ST_FINISH;
                    end
                end
            end

            dtt_pkg::ST_SCAN:
            begin
                if (take)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = idx_reg;
                    best_time_next = rd_time_reg;
                    best_age_next  = cand_age;
                    best_tag_next  = rd_tag_reg;
                end
                if (idx_reg == IDX_LAST)
                begin
                    state_next = dtt_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + dtt_pkg::IDX_BITS'(1);
                end
            end

            dtt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next      = dtt_pkg::ST_IDLE;
                    out_valid_next  = 1'b1;
                    status_next     = dtt_pkg::STS_OK;
                    fired_tag_next  = '0;
                    fired_next      = 1'b0;
                    wait_next       = '0;
                    found_slot_next = '0;
                    case (action_reg)
                        dtt_pkg::ACT_SET:
                        begin
                            if (!found_reg)
                            begin
                                status_next = dtt_pkg::STS_FULL;
                            end
                            else
                            begin
                                // Saturate the deadline when now plus delay overflows.
                                set_we  = 1'b1;
                                refs_we = 1'b1;
                                wr_addr = best_idx_reg;
                                wr_refs = dtt_pkg::REFS_ZERO;
                                if (sum_wide[dtt_pkg::TIME_BITS])
                                begin
                                    wr_time = '1;
                                end
                                valid_next[best_idx_reg] = 1'b1;
                                insert_counter_next = insert_counter_reg +
                                                      dtt_pkg::ORDER_BITS'(1);
                                found_slot_next = dtt_pkg::SLOT_BITS'(best_idx_reg);
                            end
                        end
                        dtt_pkg::ACT_QUERY:
                        begin
                            if (!found_reg)
                            begin
                                status_next = dtt_pkg::STS_EMPTY;
                            end
                            else if (best_time_reg > now_reg)
                            begin
                                wait_next = best_time_reg - now_reg;
                            end
                        end
                        dtt_pkg::ACT_FIRE:
                        begin
                            if (!found_reg)
                            begin
                                status_next = dtt_pkg::STS_EMPTY;
                            end
                            else if (best_time_reg > now_reg)
                            begin
                                status_next = dtt_pkg::STS_NOT_DUE;
                            end
                            else
                            begin
                                // A fired timer leaves the table whatever its count.
                                valid_next[best_idx_reg] = 1'b0;
                                fired_tag_next = best_tag_reg;
                                fired_next     = 1'b1;
                            end
                        end
                        dtt_pkg::ACT_FIND:
                        begin
                            if (!found_reg)
                            begin
                                status_next = dtt_pkg::STS_NOT_FOUND;
                            end
                            else
                            begin
                                found_slot_next = dtt_pkg::SLOT_BITS'(best_idx_reg);
                            end
                        end
                        dtt_pkg::ACT_ADDREF:
                        begin
                            if (!cand_valid)
                            begin
                                status_next = dtt_pkg::STS_SLOT_INVALID;
                            end
                            else if (rd_refs_reg < dtt_pkg::REFS_MAX)
                            begin
                                refs_we = 1'b1;
                                wr_refs = rd_refs_reg + dtt_pkg::REFS_ONE;
                            end
                        end
                        dtt_pkg::ACT_RELEASE:
                        begin
                            if (!cand_valid)
                            begin
                                status_next = dtt_pkg::STS_SLOT_INVALID;
                            end
                            else if (rd_refs_reg <= dtt_pkg::REFS_ONE)
                            begin
                                valid_next[idx_reg] = 1'b0;
                            end
                            else
                            begin
                                refs_we = 1'b1;
                                wr_refs = rd_refs_reg - dtt_pkg::REFS_ONE;
                            end
                        end
                        default:
                        begin
                            status_next = dtt_pkg::STS_OK;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = dtt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= dtt_pkg::ST_IDLE;
            valid_reg          <= '0;
            insert_counter_reg <= '0;
            found_reg          <= 1'b0;
            idx_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            valid_reg          <= valid_next;
            insert_counter_reg <= insert_counter_next;
            found_reg          <= found_next;
            idx_reg            <= idx_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        now_reg        <= now_next;
        tval_reg       <= tval_next;
        tag_reg        <= tag_next;
        best_idx_reg   <= best_idx_next;
        best_time_reg  <= best_time_next;
        best_age_reg   <= best_age_next;
        best_tag_reg   <= best_tag_next;
        status_reg     <= status_next;
        fired_tag_reg  <= fired_tag_next;
        fired_reg      <= fired_next;
        wait_reg       <= wait_next;
        found_slot_reg <= found_slot_next;
    end

    // Entry store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (set_we)
        begin
            deadline_mem[wr_addr] <= wr_time;
            tag_mem[wr_addr]      <= tag_reg;
            order_mem[wr_addr]    <= insert_counter_reg;
        end
        if (refs_we)
        begin
            refs_mem[wr_addr] <= wr_refs;
        end
        rd_time_reg  <= deadline_mem[idx_next];
        rd_tag_reg   <= tag_mem[idx_next];
        rd_refs_reg  <= refs_mem[idx_next];
        rd_order_reg <= order_mem[idx_next];
    end

    // Port drive.
    assign in_stall     = (state_reg != dtt_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign fired_tag    = fired_tag_reg;
    assign fired        = fired_reg;
    assign wait_seconds = wait_reg;
    assign found_slot   = found_slot_reg;

    // Checks on the sequencer.
    `DTT_ASSERT_NXT(a_accept_blocks_input, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while a beat is in work")
    `DTT_ASSERT_NXT(a_scan_ends_in_finish, clk, rst_n, state_reg == dtt_pkg::ST_SCAN && idx_reg == IDX_LAST, state_reg == dtt_pkg::ST_FINISH, "scan did not stop after the last entry")
    `DTT_ASSERT_NXT(a_finish_delivers, clk, rst_n, state_reg == dtt_pkg::ST_FINISH && !out_valid_reg, out_valid_reg && state_reg == dtt_pkg::ST_IDLE, "free output register not loaded")
    `DTT_ASSERT_IMP(a_fired_is_ok, clk, rst_n, out_valid && fired, status == dtt_pkg::STS_OK && wait_seconds == '0, "fired result carries a bad status")

endmodule

// ===== test/deadline_timer_table_unit_tb.sv =====
// Self-checking testbench for deadline_timer_table_unit: directed and random command beats,
// a beat-level model of the timer table, and random idling on both channels.
// Depends on dtt_pkg and the deadline_timer_table_unit RTL.
`timescale 1ns / 1ps

module deadline_timer_table_unit_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1425;
    localparam int TAIL_CYCLES  = 60;
    localparam int RECENT_DEPTH = 8;
    localparam int REPORT_CAP   = 60;

    // Actions the block decodes as no operation.
    localparam logic [dtt_pkg::ACTION_BITS-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [dtt_pkg::ACTION_BITS-1:0] ACT_SPARE_B = 3'd7;

    localparam logic [dtt_pkg::TIME_BITS-1:0] TIME_MAX = '1;

    // One command beat as queued for the driver, tagged with its idling phase.
    typedef struct packed {
        logic [dtt_pkg::ACTION_BITS-1:0] action;
        logic [dtt_pkg::TIME_BITS-1:0]   now;
        logic [dtt_pkg::TIME_BITS-1:0]   time_value;
        logic [dtt_pkg::TAG_BITS-1:0]    owner_tag;
        logic [dtt_pkg::SLOT_BITS-1:0]   slot;
        logic [1:0]                      phase;
    } timer_cmd_t;

    // One result beat.
    typedef struct packed {
        logic [dtt_pkg::STATUS_BITS-1:0] status;
        logic [dtt_pkg::TAG_BITS-1:0]    fired_tag;
        logic                            fired;
        logic [dtt_pkg::TIME_BITS-1:0]   wait_seconds;
        logic [dtt_pkg::SLOT_BITS-1:0]   found_slot;
    } timer_outcome_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [dtt_pkg::ACTION_BITS-1:0] action;
    logic [dtt_pkg::TIME_BITS-1:0]   now;
    logic [dtt_pkg::TIME_BITS-1:0]   time_value;
    logic [dtt_pkg::TAG_BITS-1:0]    owner_tag;
    logic [dtt_pkg::SLOT_BITS-1:0]   slot;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [dtt_pkg::STATUS_BITS-1:0] status;
    logic [dtt_pkg::TAG_BITS-1:0]    fired_tag;
    logic                            fired;
    logic [dtt_pkg::TIME_BITS-1:0]   wait_seconds;
    logic [dtt_pkg::SLOT_BITS-1:0]   found_slot;

    timer_cmd_t     held_cmd  = '0;
    timer_cmd_t     next_cmd;
    timer_outcome_t want;
    logic [1:0]     cur_phase = 2'd0;

    timer_cmd_t     cmd_q[$];
    timer_outcome_t outcome_q[$];

    int failures    = 0;
    int cycle_count = 0;

    // Model copy of the timer table.
    logic                                 live   [dtt_pkg::TABLE_DEPTH];
    logic [dtt_pkg::TIME_BITS-1:0]        due_at [dtt_pkg::TABLE_DEPTH];
    logic [dtt_pkg::TAG_BITS-1:0]         owner  [dtt_pkg::TABLE_DEPTH];
    logic signed [dtt_pkg::REFS_BITS-1:0] refs   [dtt_pkg::TABLE_DEPTH];
    logic [dtt_pkg::ORDER_BITS-1:0]       born   [dtt_pkg::TABLE_DEPTH];
    logic [dtt_pkg::ORDER_BITS-1:0]       insert_seq;

    // Generator bookkeeping: recent set deadlines so that finds can hit.
    logic [dtt_pkg::TIME_BITS-1:0] recent_due [RECENT_DEPTH];
    logic [dtt_pkg::TAG_BITS-1:0]  recent_tag [RECENT_DEPTH];
    int                            recent_wr = 0;
    int                            gen_count = 0;
    logic [1:0]                    gen_phase = 2'd0;

    assign action     = held_cmd.action;
    assign now        = held_cmd.now;
    assign time_value = held_cmd.time_value;
    assign owner_tag  = held_cmd.owner_tag;
    assign slot       = held_cmd.slot;

    deadline_timer_table_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .now          (now),
        .time_value   (time_value),
        .owner_tag    (owner_tag),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .fired_tag    (fired_tag),
        .fired        (fired),
        .wait_seconds (wait_seconds),
        .found_slot   (found_slot)
    );

    // Idling percentages per phase: none, sender only, receiver only, both.
    function automatic int sender_idle_pct(logic [1:0] ph);
        case (ph)
            2'd1:    return 56;
            2'd3:    return 36;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(logic [1:0] ph);
        case (ph)
            2'd2:    return 56;
            2'd3:    return 36;
            default: return 0;
        endcase
    endfunction

    // Random field values at the width of each port.
    function automatic logic [dtt_pkg::ACTION_BITS-1:0] any_action();
        return dtt_pkg::ACTION_BITS'($urandom_range(0, 7));
    endfunction

    function automatic logic [dtt_pkg::TIME_BITS-1:0] any_time();
        return dtt_pkg::TIME_BITS'($urandom);
    endfunction

    function automatic logic [dtt_pkg::TAG_BITS-1:0] any_tag();
        return dtt_pkg::TAG_BITS'($urandom);
    endfunction

    function automatic logic [dtt_pkg::SLOT_BITS-1:0] any_slot();
        return dtt_pkg::SLOT_BITS'($urandom);
    endfunction

    // Absolute deadline of a set, clamped at the largest time value.
    function automatic logic [dtt_pkg::TIME_BITS-1:0] deadline_of(
        logic [dtt_pkg::TIME_BITS-1:0] t0, logic [dtt_pkg::TIME_BITS-1:0] dly);
        logic [dtt_pkg::TIME_BITS:0] sum;
        sum = {1'b0, t0} + {1'b0, dly};
        return sum[dtt_pkg::TIME_BITS] ? TIME_MAX : sum[dtt_pkg::TIME_BITS-1:0];
    endfunction

    // True when entry a went in before entry b, judged by age modulo the counter width.
    function automatic logic inserted_first(int a, int b);
        logic [dtt_pkg::ORDER_BITS-1:0] age_a;
        logic [dtt_pkg::ORDER_BITS-1:0] age_b;
        age_a = insert_seq - born[a];
        age_b = insert_seq - born[b];
        return age_a > age_b;
    endfunction

    // Index of the live entry with the earliest deadline, oldest on ties, or -1.
    function automatic int earliest_live();
        int best;
        best = -1;
        for (int i = 0; i < dtt_pkg::TABLE_DEPTH; i++)
            if (live[i] && (best < 0 || due_at[i] < due_at[best] ||
                (due_at[i] == due_at[best] && inserted_first(i, best))))
                best = i;
        return best;
    endfunction

    // Applies one command to the model table and returns the result it must produce.
    function automatic timer_outcome_t table_outcome(timer_cmd_t c);
        timer_outcome_t r;
        int e;
        r = '0;
        e = -1;
        case (c.action)
            dtt_pkg::ACT_SET:
            begin
                r.status = dtt_pkg::STS_FULL;
                for (int i = 0; i < dtt_pkg::TABLE_DEPTH; i++)
                    if (e < 0 && !live[i])
                        e = i;
                if (e >= 0)
                begin
                    due_at[e]    = deadline_of(c.now, c.time_value);
                    owner[e]     = c.owner_tag;
                    refs[e]      = dtt_pkg::REFS_ZERO;
                    born[e]      = insert_seq;
                    insert_seq   = insert_seq + dtt_pkg::ORDER_BITS'(1);
                    live[e]      = 1'b1;
                    r.status     = dtt_pkg::STS_OK;
                    r.found_slot = e[dtt_pkg::SLOT_BITS-1:0];
                end
            end
            dtt_pkg::ACT_QUERY, dtt_pkg::ACT_FIRE:
            begin
                e = earliest_live();
                if (e < 0)
                    r.status = dtt_pkg::STS_EMPTY;
                else if (due_at[e] > c.now)
                begin
                    if (c.action == dtt_pkg::ACT_QUERY)
                        r.wait_seconds = due_at[e] - c.now;
                    else
                        r.status = dtt_pkg::STS_NOT_DUE;
                end
                else if (c.action == dtt_pkg::ACT_FIRE)
                begin
                    // A fired entry goes whatever its reference count.
                    live[e]     = 1'b0;
                    r.fired_tag = owner[e];
                    r.fired     = 1'b1;
                end
            end
            dtt_pkg::ACT_FIND:
            begin
                for (int i = 0; i < dtt_pkg::TABLE_DEPTH; i++)
                    if (live[i] && due_at[i] == c.time_value && owner[i] == c.owner_tag &&
                        (e < 0 || inserted_first(i, e)))
                        e = i;
                if (e < 0)
                    r.status = dtt_pkg::STS_NOT_FOUND;
                else
                    r.found_slot = e[dtt_pkg::SLOT_BITS-1:0];
            end
            dtt_pkg::ACT_ADDREF, dtt_pkg::ACT_RELEASE:
            begin
                if (!live[c.slot])
                    r.status = dtt_pkg::STS_SLOT_INVALID;
                else if (c.action == dtt_pkg::ACT_ADDREF)
                begin
                    if (refs[c.slot] < dtt_pkg::REFS_MAX)
                        refs[c.slot] = refs[c.slot] + dtt_pkg::REFS_ONE;
                end
                else if (refs[c.slot] <= dtt_pkg::REFS_ONE)
                    live[c.slot] = 1'b0;
                else
                    refs[c.slot] = refs[c.slot] - dtt_pkg::REFS_ONE;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Queues one command beat and remembers set deadlines for later finds.
    task automatic push_cmd(logic [dtt_pkg::ACTION_BITS-1:0] a,
                            logic [dtt_pkg::TIME_BITS-1:0] t,
                            logic [dtt_pkg::TIME_BITS-1:0] tv,
                            logic [dtt_pkg::TAG_BITS-1:0] tag,
                            logic [dtt_pkg::SLOT_BITS-1:0] s);
        timer_cmd_t c;
        c.action     = a;
        c.now        = t;
        c.time_value = tv;
        c.owner_tag  = tag;
        c.slot       = s;
        c.phase      = gen_phase;
        cmd_q.push_back(c);
        if (a == dtt_pkg::ACT_SET)
        begin
            recent_due[recent_wr] = deadline_of(t, tv);
            recent_tag[recent_wr] = tag;
            recent_wr = (recent_wr + 1) % RECENT_DEPTH;
        end
        gen_count++;
    endtask

    function automatic logic [dtt_pkg::TIME_BITS-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 70)
            return dtt_pkg::TIME_BITS'($urandom_range(1, 40));
        if (r < 85)
            return any_time();
        return TIME_MAX - dtt_pkg::TIME_BITS'($urandom_range(0, 3));
    endfunction

    // A narrow tag pool makes equal deadline and tag pairs likely.
    function automatic logic [dtt_pkg::TAG_BITS-1:0] pick_tag();
        if ($urandom_range(0, 99) < 50)
            return dtt_pkg::TAG_BITS'($urandom_range(0, 3));
        return any_tag();
    endfunction

    function automatic logic [dtt_pkg::TIME_BITS-1:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return dtt_pkg::TIME_BITS'($urandom_range(0, 1000));
        if (r < 75)
            return any_time();
        return TIME_MAX - dtt_pkg::TIME_BITS'($urandom_range(0, 200));
    endfunction

    function automatic logic [dtt_pkg::SLOT_BITS-1:0] pick_slot();
        if ($urandom_range(0, 99) < 60)
            return dtt_pkg::SLOT_BITS'($urandom_range(0, 5));
        return dtt_pkg::SLOT_BITS'($urandom_range(0, dtt_pkg::TABLE_DEPTH - 1));
    endfunction

    task automatic note_mismatch(string field, logic [31:0] exp_val, logic [31:0] got_val);
        failures++;
        if (failures <= REPORT_CAP)
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, exp_val, got_val);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset is held low from the start and then released for good.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, outcome_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Driver: predicts each accepted beat and presents the next one, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            held_cmd <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                outcome_q.push_back(table_outcome(held_cmd));
            if (!in_valid || !in_stall)
            begin
                if (cmd_q.size() > 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct(cmd_q[0].phase))
                begin
                    next_cmd  = cmd_q.pop_front();
                    held_cmd  <= next_cmd;
                    cur_phase <= next_cmd.phase;
                    in_valid  <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_CAP)
                        $display("%0t: result beat with none expected: expected nothing, %s %0d",
                                 $time, "actual status", status);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(status));
                    if (fired_tag !== want.fired_tag)
                        note_mismatch("fired_tag", 32'(want.fired_tag), 32'(fired_tag));
                    if (fired !== want.fired)
                        note_mismatch("fired", 32'(want.fired), 32'(fired));
                    if (wait_seconds !== want.wait_seconds)
                        note_mismatch("wait_seconds", want.wait_seconds, wait_seconds);
                    if (found_slot !== want.found_slot)
                        note_mismatch("found_slot", 32'(want.found_slot), 32'(found_slot));
                end
            end
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct(cur_phase));
        end
    end

    // Stimulus: directed beats, then random sequences over four idling phases.
    initial
    begin : stimulus
        int directed_count;
        int done;
        int n;
        int op;
        int r;
        int pick;
        logic refcount_done;
        logic [dtt_pkg::TIME_BITS-1:0] gen_now;
        logic [dtt_pkg::TIME_BITS-1:0] dly;
        logic [dtt_pkg::TIME_BITS-1:0] dl;
        logic [dtt_pkg::TAG_BITS-1:0]  tg;

        for (int i = 0; i < dtt_pkg::TABLE_DEPTH; i++)
        begin
            live[i]   = 1'b0;
            due_at[i] = '0;
            owner[i]  = '0;
            refs[i]   = dtt_pkg::REFS_ZERO;
            born[i]   = '0;
        end
        insert_seq = '0;
        for (int i = 0; i < RECENT_DEPTH; i++)
        begin
            recent_due[i] = '0;
            recent_tag[i] = '0;
        end
        refcount_done = 1'b0;

        // Empty table, bad slots and the spare actions.
        push_cmd(dtt_pkg::ACT_QUERY, 32'd5, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_FIRE, TIME_MAX, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_FIND, 32'd0, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_ADDREF, 32'd0, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_RELEASE, 32'd0, 32'd0, 16'd0, 4'd15);
        push_cmd(ACT_SPARE_A, TIME_MAX, TIME_MAX, 16'hFFFF, 4'd15);
        push_cmd(ACT_SPARE_B, 32'd0, 32'd0, 16'd0, 4'd0);
        // Two equal deadlines, a saturated one and one already due.
        push_cmd(dtt_pkg::ACT_SET, 32'd100, 32'd50, 16'hFFFF, 4'd0);
        push_cmd(dtt_pkg::ACT_SET, 32'd100, 32'd50, 16'h0000, 4'd0);
        push_cmd(dtt_pkg::ACT_SET, 32'hFFFF_FFF0, TIME_MAX, 16'h1234, 4'd0);
        push_cmd(dtt_pkg::ACT_SET, 32'd0, 32'd0, 16'hA5A5, 4'd0);
        push_cmd(dtt_pkg::ACT_QUERY, 32'd0, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_FIRE, 32'd0, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_QUERY, 32'd120, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_FIRE, 32'd120, 32'd0, 16'd0, 4'd0);
        // Finds: hit, saturated hit, miss on tag.
        push_cmd(dtt_pkg::ACT_FIND, 32'd0, 32'd150, 16'h0000, 4'd0);
        push_cmd(dtt_pkg::ACT_FIND, 32'd0, TIME_MAX, 16'h1234, 4'd0);
        push_cmd(dtt_pkg::ACT_FIND, 32'd0, 32'd150, 16'h0001, 4'd0);
        // Count up and down, then fire on the tie while the count is still held.
        push_cmd(dtt_pkg::ACT_ADDREF, 32'd0, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_ADDREF, 32'd0, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_RELEASE, 32'd0, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_FIRE, 32'd150, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_RELEASE, 32'd0, 32'd0, 16'd0, 4'd1);
        push_cmd(dtt_pkg::ACT_QUERY, TIME_MAX, 32'd0, 16'd0, 4'd0);
        push_cmd(dtt_pkg::ACT_FIRE, TIME_MAX, 32'd0, 16'd0, 4'd0);
        directed_count = gen_count;

        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            gen_phase = 2'((done * 4) / RANDOM_ITEMS);
            if (!refcount_done && done >= RANDOM_ITEMS / 2)
            begin
                // Empty the table, then drive one entry's count into saturation.
                gen_now = pick_base();
                repeat (dtt_pkg::TABLE_DEPTH + 1)
                    push_cmd(dtt_pkg::ACT_FIRE, TIME_MAX, any_time(), any_tag(), any_slot());
                push_cmd(dtt_pkg::ACT_SET, gen_now, pick_delay(), pick_tag(), any_slot());
                repeat (dtt_pkg::REFS_MAX + 3)
                    push_cmd(dtt_pkg::ACT_ADDREF, gen_now, any_time(), any_tag(), 4'd0);
                repeat (3)
                    push_cmd(dtt_pkg::ACT_RELEASE, gen_now, any_time(), any_tag(), 4'd0);
                push_cmd(dtt_pkg::ACT_QUERY, gen_now, any_time(), any_tag(), any_slot());
                refcount_done = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    // Working session: time moves forward in small steps.
                    gen_now = pick_base();
                    n = $urandom_range(8, 30);
                    repeat (n)
                    begin
                        gen_now = gen_now + dtt_pkg::TIME_BITS'($urandom_range(0, 20));
                        op = $urandom_range(0, 99);
                        if (op < 35)
                            push_cmd(dtt_pkg::ACT_SET, gen_now, pick_delay(), pick_tag(),
                                     any_slot());
                        else if (op < 50)
                            push_cmd(dtt_pkg::ACT_QUERY, gen_now, any_time(), any_tag(),
                                     any_slot());
                        else if (op < 68)
                            push_cmd(dtt_pkg::ACT_FIRE, gen_now, any_time(), any_tag(),
                                     any_slot());
                        else if (op < 80)
                        begin
                            pick = $urandom_range(0, RECENT_DEPTH - 1);
                            dl = recent_due[pick];
                            tg = recent_tag[pick];
                            case ($urandom_range(0, 9))
                                0:       dl = dl + 32'd1;
                                1:       tg = tg ^ 16'd1;
                                2:       dl = any_time();
                                default: ;
                            endcase
                            push_cmd(dtt_pkg::ACT_FIND, gen_now, dl, tg, any_slot());
                        end
                        else if (op < 90)
                            push_cmd(dtt_pkg::ACT_ADDREF, gen_now, any_time(), any_tag(),
                                     pick_slot());
                        else
                            push_cmd(dtt_pkg::ACT_RELEASE, gen_now, any_time(), any_tag(),
                                     pick_slot());
                    end
                end
                else if (r < 75)
                begin
                    // Fill past capacity, often with identical timers, then drain a few.
                    gen_now = pick_base();
                    dly = pick_delay();
                    tg = pick_tag();
                    n = dtt_pkg::TABLE_DEPTH + 1 + $urandom_range(0, 2);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            push_cmd(dtt_pkg::ACT_SET, gen_now, dly, tg, any_slot());
                        else
                            push_cmd(dtt_pkg::ACT_SET, gen_now, pick_delay(), pick_tag(),
                                     any_slot());
                    end
                    push_cmd(dtt_pkg::ACT_FIND, gen_now, deadline_of(gen_now, dly), tg,
                             any_slot());
                    push_cmd(dtt_pkg::ACT_QUERY, gen_now, any_time(), any_tag(), any_slot());
                    repeat ($urandom_range(2, 8))
                        push_cmd(dtt_pkg::ACT_FIRE, TIME_MAX, any_time(), any_tag(),
                                 any_slot());
                end
                else if (r < 88)
                begin
                    // Noise: every field at random.
                    repeat ($urandom_range(5, 15))
                        push_cmd(any_action(), any_time(), any_time(), any_tag(), any_slot());
                end
                else
                begin
                    // Drain by firing at the latest time or releasing.
                    repeat ($urandom_range(4, dtt_pkg::TABLE_DEPTH + 2))
                    begin
                        if ($urandom_range(0, 3) == 0)
                            push_cmd(dtt_pkg::ACT_RELEASE, any_time(), any_time(), any_tag(),
                                     pick_slot());
                        else
                            push_cmd(dtt_pkg::ACT_FIRE, TIME_MAX, any_time(), any_tag(),
                                     any_slot());
                    end
                end
            end
            done = gen_count - directed_count;
        end

        // Wait for every beat to go in and every result to come back.
        while (cmd_q.size() != 0 || in_valid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (outcome_q.size() != 0)
        begin
            failures++;
            $display("%0t: results outstanding: expected 0, actual %0d", $time, outcome_q.size());
        end
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== deadline_timer_table_unit.f =====
+incdir+hdl
hdl/dtt_pkg.sv
hdl/dtt_cmp_unit.sv
hdl/deadline_timer_table_unit.sv
test/deadline_timer_table_unit_tb.sv
